/* src/sktl_pkg.sv */
// ----------------------------------------------------------------------------
// sktl_pkg: shared types and constants
// Entry layout, table depth and sequencer states of the sorted key table.
// ----------------------------------------------------------------------------
package sktl_pkg;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CountW  = $clog2(Depth + 1);
  localparam int unsigned KeyW    = 160;
  localparam int unsigned ValW    = 160;
  localparam int unsigned PosW    = 10;
  localparam int unsigned EntryW  = KeyW + ValW + 1;

  localparam logic ReqLookup = 1'b0;
  localparam logic ReqSet    = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            done;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    entry_t            wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StProbe,
    StCompare,
    StShiftRd,
    StShiftWr,
    StWrite,
    StOut
  } state_e;

endpackage

/* src/sktl_mem.sv */
// ----------------------------------------------------------------------------
// sktl_mem: entry memory
// One write port and one read port; read data is registered, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module sktl_mem (
  input  logic              clk_i,
  input  sktl_pkg::mem_req_t req_i,
  output sktl_pkg::entry_t  rdata_o
);
  import sktl_pkg::*;

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

/* src/sorted_key_table_lookup_insert.sv */
// A hit, or an insert refused on a full table, runs p binary-search probes, each a StProbe
// and a StCompare state; p is at most log2(Depth)+1, 11 at 1024.
// An insert then moves each entry above the insertion point up one slot, a StShiftRd read and
// a StShiftWr write per entry, through the single read and write port of the entry memory.
// One request is in flight at a time; a result held at the output stalls the next request.
// Reset clears the entry count; memory contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_insert: sorted 160-bit key table
// Binary search with insert-by-shift over a single entry memory.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_insert (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key_hi[63:0], key_mid[127:64], key_lo[159:128], value_hi[223:160],
  // value_mid[287:224], value_lo[319:288]
  input  logic [319:0] s_axis_tdata,
  // tuser: req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: position[9:0], out_value_hi[73:10], out_value_mid[137:74],
  // out_value_lo[169:138], zero above
  output logic [175:0] m_axis_tdata,
  // tuser: hit[0], inserted[1], table_full[2], done_flag[3]
  output logic [3:0]   m_axis_tuser
);
  import sktl_pkg::*;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic req_q, req_d;
  logic found_q, found_d, ins_q, ins_d, full_q, full_d;
  entry_t res_q, res_d;
  logic ovalid_q, ovalid_d;
  logic [3:0] ouser_q, ouser_d;
  logic [175:0] odata_q, odata_d;
  mem_req_t mreq;
  entry_t rdata;
  logic [CountW-1:0] mid;

  sktl_mem u_mem (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  always_comb begin
    logic [KeyW-1:0] rk;
    state_d = state_q; count_d = count_q; lo_d = lo_q; hi_d = hi_q; idx_d = idx_q;
    key_d = key_q; val_d = val_q; req_d = req_q; found_d = found_q; ins_d = ins_q;
    full_d = full_q; res_d = res_q; ovalid_d = ovalid_q; ouser_d = ouser_q;
    odata_d = odata_q;
    mreq = '0;
    rk = {rdata.key[159:96], rdata.key[95:32], rdata.key[31:0]};
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          // Key packed hi|mid|lo so a plain compare gives byte order.
          key_d = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[159:128]};
          val_d = {s_axis_tdata[223:160], s_axis_tdata[287:224], s_axis_tdata[319:288]};
          req_d = s_axis_tuser;
          lo_d = '0; hi_d = count_q; found_d = 1'b0; ins_d = 1'b0; full_d = 1'b0;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (lo_q < hi_q) begin
          mreq.re = 1'b1; mreq.raddr = mid[AddrW-1:0]; idx_d = mid;
          state_d = StCompare;
        end else if (count_q >= CountW'(Depth)) begin
          idx_d = lo_q; full_d = 1'b1; res_d = '0; state_d = StOut;
        end else begin
          idx_d = count_q; ins_d = 1'b1; state_d = StShiftRd;
        end
      end
      StCompare: begin
        if (rk == key_q) begin
          found_d = 1'b1; res_d = rdata; state_d = StWrite;
        end else begin
          if (key_q < rk) hi_d = idx_q; else lo_d = idx_q + 1'b1;
          state_d = StProbe;
        end
      end
      StShiftRd: begin
        // idx_q walks down from count to the insertion point lo_q.
        if (idx_q > lo_q) begin
          mreq.re = 1'b1; mreq.raddr = AddrW'(idx_q - 1'b1);
          state_d = StShiftWr;
        end else begin
          res_d = '{key: key_q, value: '0, done: 1'b0};
          count_d = count_q + 1'b1;
          state_d = StWrite;
        end
      end
      StShiftWr: begin
        mreq.we = 1'b1; mreq.waddr = idx_q[AddrW-1:0]; mreq.wdata = rdata;
        idx_d = idx_q - 1'b1; state_d = StShiftRd;
      end
      StWrite: begin
        if (req_q == ReqSet) begin
          res_d.value = val_q; res_d.done = 1'b1;
        end
        mreq.we = ins_q || (req_q == ReqSet);
        mreq.waddr = idx_q[AddrW-1:0];
        mreq.wdata = '{key: key_q, value: res_d.value, done: res_d.done};
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d = {6'b0, res_q.value[31:0], res_q.value[95:32], res_q.value[159:96],
                     idx_q[PosW-1:0]};
          ouser_d = {res_q.done, full_q, ins_q, found_q};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; idx_q <= idx_d; key_q <= key_d; val_q <= val_d;
    req_q <= req_d; found_q <= found_d; ins_q <= ins_d; full_q <= full_d;
    res_q <= res_d; ouser_q <= ouser_d; odata_q <= odata_d;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth)) else $error("entry count overflow");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(m_axis_tuser[2:0]) <= 1) else $error("flags clash");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata[169:10] == '0 && !m_axis_tuser[3]))
    else $error("full result not cleared");

endmodule
